>>> design/sid_pkg.sv
`timescale 1ns / 1ps

package sid_pkg;

  localparam int SET_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(SET_DEPTH);
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int FOUND_W   = 11;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PROBE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_NONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN2 = 4'b0010,
    ST_SCAN1 = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

>>> design/sid_store.sv
`timescale 1ns / 1ps

module sid_store (
  input  logic                          clk_i,
  input  sid_pkg::mem_req_t             req_i,
  output logic [sid_pkg::DATA_W-1:0]    rdata_o
);
  import sid_pkg::*;

  logic [DATA_W-1:0] mem_q [SET_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.addr];
  end

endmodule

>>> design/set_intersection_dedup.sv
`timescale 1ns / 1ps
// set intersection with duplicate removal
// input channel (in_valid_i/in_ready_o) takes one word: req_type_i, value_i,
// first_set_done_i. a clear empties both stores, an append loads value_i into
// the second-set store, a probe tests value_i as a first-set element.
// output channel (out_valid_o/out_ready_i) gives exactly one word per input
// word: status_o, common_value_o, found_count_o, end_marker_o.
// clear, append and unused codes skip the scan and go straight to the result.
// a probe scans the second-set store (one entry per cycle, n2 entries) and,
// on a hit, the found store (nf entries); each store has a single read port.
// a scan stops early on the first match.
// one word is worked on at a time; the next word is accepted as soon as the
// result is in the output register, even while that result is still stalled.
// a stalled output holds its word; the block waits before loading another.
// reset clears both counts and the handshake state; store contents are not
// cleared and no entry above a count is ever compared.
module set_intersection_dedup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sid_pkg::REQ_W-1:0]       req_type_i,
  input  logic signed [sid_pkg::DATA_W-1:0] value_i,
  input  logic                            first_set_done_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sid_pkg::STAT_W-1:0]      status_o,
  output logic signed [sid_pkg::DATA_W-1:0] common_value_o,
  output logic [sid_pkg::FOUND_W-1:0]     found_count_o,
  output logic                            end_marker_o
);
  import sid_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   second_cnt_q, second_cnt_d;
  logic [CNT_W-1:0]   found_cnt_q, found_cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic               done_q, done_d;
  logic [STAT_W-1:0]  pend_stat_q, pend_stat_d;
  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_stat_q;
  logic [DATA_W-1:0]  out_val_q;
  logic [FOUND_W-1:0] out_cnt_q;
  logic               out_done_q;

  mem_req_t           sec_req, fnd_req;
  logic [DATA_W-1:0]  sec_rdata, fnd_rdata;
  logic               in_acc, out_load;

  sid_store u_second (
    .clk_i   (clk_i),
    .req_i   (sec_req),
    .rdata_o (sec_rdata)
  );

  sid_store u_found (
    .clk_i   (clk_i),
    .req_i   (fnd_req),
    .rdata_o (fnd_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    second_cnt_d = second_cnt_q;
    found_cnt_d  = found_cnt_q;
    idx_d        = idx_q;
    cmp_vld_d    = 1'b0;
    val_d        = val_q;
    done_d       = done_q;
    pend_stat_d  = pend_stat_q;
    sec_req.we    = 1'b0;
    sec_req.addr  = idx_q[ADDR_W-1:0];
    sec_req.wdata = val_q;
    fnd_req.we    = 1'b0;
    fnd_req.addr  = idx_q[ADDR_W-1:0];
    fnd_req.wdata = val_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          val_d       = value_i;
          done_d      = first_set_done_i;
          pend_stat_d = STAT_NONE;
          idx_d       = '0;
          state_d     = ST_FIN;
          case (req_type_i)
            REQ_CLEAR: begin
              second_cnt_d = '0;
              found_cnt_d  = '0;
            end
            REQ_APPEND: begin
              if (second_cnt_q < CNT_W'(SET_DEPTH)) begin
                sec_req.we    = 1'b1;
                sec_req.addr  = second_cnt_q[ADDR_W-1:0];
                sec_req.wdata = value_i;
                second_cnt_d  = second_cnt_q + 1'b1;
              end else begin
                pend_stat_d = STAT_FULL;
              end
            end
            REQ_PROBE: begin
              state_d = ST_SCAN2;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN2: begin
        if (cmp_vld_q && (sec_rdata == val_q)) begin
          idx_d   = '0;
          state_d = ST_SCAN1;
        end else if (idx_q < second_cnt_q) begin
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = ST_FIN;
        end
      end
      ST_SCAN1: begin
        if (cmp_vld_q && (fnd_rdata == val_q)) begin
          state_d = ST_FIN;
        end else if (idx_q < found_cnt_q) begin
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = ST_FIN;
          if (found_cnt_q < CNT_W'(SET_DEPTH)) begin
            fnd_req.we   = 1'b1;
            fnd_req.addr = found_cnt_q[ADDR_W-1:0];
            found_cnt_d  = found_cnt_q + 1'b1;
            pend_stat_d  = STAT_EMIT;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      second_cnt_q <= '0;
      found_cnt_q  <= '0;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      second_cnt_q <= second_cnt_d;
      found_cnt_q  <= found_cnt_d;
      idx_q        <= idx_d;
      cmp_vld_q    <= cmp_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    done_q      <= done_d;
    pend_stat_q <= pend_stat_d;
    if (out_load) begin
      out_stat_q <= pend_stat_q;
      out_val_q  <= (pend_stat_q == STAT_EMIT) ? val_q : '0;
      out_cnt_q  <= FOUND_W'(found_cnt_q);
      out_done_q <= done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_stat_q;
  assign common_value_o = out_val_q;
  assign found_count_o  = out_cnt_q;
  assign end_marker_o   = out_done_q;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sid_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 290;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 2 * SET_DEPTH + 64;
  localparam int CYCLE_LIMIT  = 10000000;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_MOSTLY} stall_mode_e;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  common_value;
    logic [FOUND_W-1:0] found_count;
    logic               end_marker;
  } result_t;

  class intersect_scoreboard;
    logic [DATA_W-1:0] second_vals [SET_DEPTH];
    logic [DATA_W-1:0] found_vals [SET_DEPTH];
    int n_second;
    int n_found;
    result_t pending_results [$];
    int errors;
    int checked;

    function new();
      n_second = 0;
      n_found  = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    // intersection predictor: one result per accepted word
    function void note_word(logic [REQ_W-1:0] req, logic [DATA_W-1:0] val, logic done);
      result_t r;
      bit in_second;
      bit in_found;
      r.status       = STAT_NONE;
      r.common_value = '0;
      r.end_marker   = done;
      case (req)
        REQ_CLEAR: begin
          n_second = 0;
          n_found  = 0;
        end
        REQ_APPEND: begin
          if (n_second < SET_DEPTH) begin
            second_vals[n_second] = val;
            n_second++;
          end else begin
            r.status = STAT_FULL;
          end
        end
        REQ_PROBE: begin
          in_second = 1'b0;
          in_found  = 1'b0;
          for (int k = 0; k < n_second; k++) if (second_vals[k] == val) in_second = 1'b1;
          for (int k = 0; k < n_found; k++) if (found_vals[k] == val) in_found = 1'b1;
          if (in_second && !in_found && n_found < SET_DEPTH) begin
            found_vals[n_found] = val;
            n_found++;
            r.status       = STAT_EMIT;
            r.common_value = val;
          end
        end
        default: ;
      endcase
      r.found_count = n_found[FOUND_W-1:0];
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] value,
                      logic [FOUND_W-1:0] count, logic marker);
      result_t exp_r;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("word %0d arrived with nothing pending", checked));
        return;
      end
      exp_r = pending_results.pop_front();
      if (status !== exp_r.status)
        report($sformatf("word %0d status %0d, want %0d", checked, status, exp_r.status));
      if (value !== exp_r.common_value)
        report($sformatf("word %0d common_value %h, want %h", checked, value,
                         exp_r.common_value));
      if (count !== exp_r.found_count)
        report($sformatf("word %0d found_count %0d, want %0d", checked, count,
                         exp_r.found_count));
      if (marker !== exp_r.end_marker)
        report($sformatf("word %0d end_marker %b, want %b", checked, marker,
                         exp_r.end_marker));
    endtask
  endclass

  bit clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [REQ_W-1:0] req_type_i;
  logic signed [DATA_W-1:0] value_i;
  logic first_set_done_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [STAT_W-1:0] status_o;
  logic signed [DATA_W-1:0] common_value_o;
  logic [FOUND_W-1:0] found_count_o;
  logic end_marker_o;

  intersect_scoreboard sb;
  int burst_left;
  int random_words;
  int cycle_count;
  bit hold_pending;
  logic [DATA_W-1:0] fill_vals [SET_DEPTH];
  logic [DATA_W-1:0] pool [16];

  set_intersection_dedup DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .first_set_done_i(first_set_done_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .common_value_o  (common_value_o),
    .found_count_o   (found_count_o),
    .end_marker_o    (end_marker_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [DATA_W-1:0] random_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val,
                           input logic done);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    value_i          <= val;
    first_set_done_i <= done;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(req, val, done);
    burst_left--;
    if (req != REQ_UNUSED) random_words++;
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, common_value_o, found_count_o, end_marker_o);
  end

  initial begin
    stall_mode_e mode;
    logic [15:0] pat;
    int phase;
    out_ready_i = 1'b0;
    mode = RX_ALWAYS;
    pat = '0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_pending = 1'b0;
      end
      if (phase == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        pat = 16'($urandom);
        phase = 64;
      end
      phase--;
      case (mode)
        RX_ALWAYS:  out_ready_i <= 1'b1;
        RX_COIN:    out_ready_i <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_ready_i <= pat[phase % 16];
        default:    out_ready_i <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n;
    int pool_size;
    logic [REQ_W-1:0] rq;
    sb = new();
    burst_left = 0;
    random_words = 0;
    hold_pending = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_CLEAR;
    value_i = '0;
    first_set_done_i = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, repeats, end marker, unused code, clear
    send_word(REQ_PROBE, 32'h0000_0005, 1'b0);
    send_word(REQ_APPEND, 32'h8000_0000, 1'b0);
    send_word(REQ_APPEND, 32'h7fff_ffff, 1'b0);
    send_word(REQ_APPEND, 32'h0000_0000, 1'b0);
    send_word(REQ_APPEND, 32'hffff_ffff, 1'b0);
    send_word(REQ_APPEND, 32'h7fff_ffff, 1'b0);
    send_word(REQ_PROBE, 32'h7fff_ffff, 1'b0);
    send_word(REQ_PROBE, 32'h7fff_ffff, 1'b0);
    send_word(REQ_PROBE, 32'h8000_0000, 1'b1);
    send_word(REQ_PROBE, 32'h8000_0000, 1'b0);
    send_word(REQ_PROBE, 32'h8000_0001, 1'b0);
    send_word(REQ_UNUSED, 32'hffff_ffff, 1'b1);
    send_word(REQ_PROBE, 32'h0000_0000, 1'b0);
    send_word(REQ_PROBE, 32'hffff_ffff, 1'b1);
    send_word(REQ_CLEAR, 32'h1234_5678, 1'b1);
    send_word(REQ_PROBE, 32'h7fff_ffff, 1'b0);
    send_word(REQ_APPEND, 32'h5555_5555, 1'b0);
    send_word(REQ_APPEND, 32'haaaa_aaaa, 1'b0);
    send_word(REQ_PROBE, 32'haaaa_aaaa, 1'b0);
    send_word(REQ_PROBE, 32'h5555_5555, 1'b1);
    wait_results_done();

    // fill the second store, overflow it, probe across its whole depth
    send_word(REQ_CLEAR, random_value(), 1'b0);
    for (int i = 0; i < SET_DEPTH; i++) begin
      fill_vals[i] = (i > 0 && i % 5 == 0) ? fill_vals[$urandom_range(0, i - 1)]
                                            : random_value();
      send_word(REQ_APPEND, fill_vals[i], 1'b0);
    end
    send_word(REQ_APPEND, random_value(), 1'b0);
    send_word(REQ_APPEND, random_value(), 1'b1);
    send_word(REQ_APPEND, fill_vals[3], 1'b0);
    send_word(REQ_PROBE, fill_vals[SET_DEPTH - 1], 1'b0);
    send_word(REQ_PROBE, fill_vals[SET_DEPTH - 1], 1'b0);
    send_word(REQ_PROBE, fill_vals[0], 1'b0);
    send_word(REQ_PROBE, fill_vals[SET_DEPTH / 2], 1'b0);
    send_word(REQ_PROBE, random_value(), 1'b0);
    send_word(REQ_PROBE, fill_vals[0], 1'b1);
    send_word(REQ_CLEAR, random_value(), 1'b0);
    wait_results_done();

    random_words = 0;
    hold_pending = 1'b1;
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          rq = REQ_W'($urandom_range(0, 3));
          send_word(rq, random_value(), 1'($urandom_range(0, 1)));
        end
      end else begin
        pool_size = $urandom_range(1, 12);
        for (int i = 0; i < pool_size; i++) pool[i] = random_value();
        if ($urandom_range(0, 4) != 0)
          send_word(REQ_CLEAR, random_value(), 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 16);
        repeat (n) send_word(REQ_APPEND, pool[$urandom_range(0, pool_size - 1)], 1'b0);
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
          send_word(REQ_PROBE, ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, pool_size - 1)]
                                                          : random_value(), i == n - 1);
      end
      if ($urandom_range(0, 7) == 0) wait_results_done();
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
